### hw/rtl/tal_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Thumb ALU with flags.
// Used by tal_shift, tal_exec and thumb_alu_with_flags; depends on nothing.
package tal_pkg;

	localparam int DATA_W  = 32;
	localparam int CMD_W   = 5;
	localparam int FLAGS_W = 4;
	localparam int SHAMT_W = 8;

	// Command codes: Thumb register ALU opcodes, then the extra forms
	localparam logic [CMD_W-1:0] CMD_AND     = 5'd0;
	localparam logic [CMD_W-1:0] CMD_EOR     = 5'd1;
	localparam logic [CMD_W-1:0] CMD_LSL     = 5'd2;
	localparam logic [CMD_W-1:0] CMD_LSR     = 5'd3;
	localparam logic [CMD_W-1:0] CMD_ASR     = 5'd4;
	localparam logic [CMD_W-1:0] CMD_ADC     = 5'd5;
	localparam logic [CMD_W-1:0] CMD_SBC     = 5'd6;
	localparam logic [CMD_W-1:0] CMD_ROR     = 5'd7;
	localparam logic [CMD_W-1:0] CMD_TST     = 5'd8;
	localparam logic [CMD_W-1:0] CMD_NEG     = 5'd9;
	localparam logic [CMD_W-1:0] CMD_CMP     = 5'd10;
	localparam logic [CMD_W-1:0] CMD_CMN     = 5'd11;
	localparam logic [CMD_W-1:0] CMD_ORR     = 5'd12;
	localparam logic [CMD_W-1:0] CMD_MUL     = 5'd13;
	localparam logic [CMD_W-1:0] CMD_BIC     = 5'd14;
	localparam logic [CMD_W-1:0] CMD_MVN     = 5'd15;
	localparam logic [CMD_W-1:0] CMD_LSL_IMM = 5'd16;
	localparam logic [CMD_W-1:0] CMD_LSR_IMM = 5'd17;
	localparam logic [CMD_W-1:0] CMD_ASR_IMM = 5'd18;
	localparam logic [CMD_W-1:0] CMD_ADD     = 5'd19;
	localparam logic [CMD_W-1:0] CMD_SUB     = 5'd20;
	localparam logic [CMD_W-1:0] CMD_MOV_IMM = 5'd21;
	localparam logic [CMD_W-1:0] CMD_CMP_IMM = 5'd22;

	// Flag bit positions
	localparam int FLAG_N = 3;
	localparam int FLAG_Z = 2;
	localparam int FLAG_C = 1;
	localparam int FLAG_V = 0;

	// Shifter operation codes
	localparam logic [1:0] SH_LSL = 2'd0;
	localparam logic [1:0] SH_LSR = 2'd1;
	localparam logic [1:0] SH_ASR = 2'd2;
	localparam logic [1:0] SH_ROR = 2'd3;

	// Shift by 32, used for immediate LSR/ASR with a zero amount
	localparam logic [SHAMT_W-1:0] SHAMT_WORD = 8'd32;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [DATA_W-1:0] operand_a;
		logic [DATA_W-1:0] operand_b;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0]  result_value;
		logic               write_result;
		logic [FLAGS_W-1:0] flags_out;
	} out_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [SHAMT_W-1:0] amount;
	} shift_ctl_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              carry;
	} shift_res_t;

endpackage

### hw/rtl/thumb_alu_with_flags.sv
`timescale 1ns / 1ps
// Top level of the Thumb ALU with flags: input register, execute logic, result register.
// Depends on tal_pkg and tal_exec.

// Executes one Thumb data-processing command per item and keeps the NZCV flags
// locally. One item is accepted every cycle when the result side does not stall.
// The input register loads the item at its accepting edge. The result register loads
// from the input register at an edge where the result side is free, and the result
// is presented from the result register. The flag register is
// updated in the same edge that loads the result register, so an item that
// follows directly sees the flags of its predecessor. Undefined command codes
// give a zero result, no write and the flags unchanged. Flags clear on reset.
module thumb_alu_with_flags (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  tal_pkg::in_item_t   cmd_item,
	output logic                res_valid,
	input  logic                res_stall,
	output tal_pkg::out_item_t  res_item
);

	logic                          valid_s1;
	tal_pkg::in_item_t             item_s1;
	logic                          res_valid_q;
	tal_pkg::out_item_t            res_q;
	logic [tal_pkg::FLAGS_W-1:0]   flags_q;
	tal_pkg::out_item_t            exec_res;
	logic                          out_free;
	logic                          advance;
	logic                          cmd_take;

	// Handshake: the result register frees when empty or taken
	assign out_free  = !res_valid_q || !res_stall;
	assign advance   = valid_s1 && out_free;
	assign cmd_stall = valid_s1 && !out_free;
	assign cmd_take  = cmd_valid && !cmd_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			item_s1 <= cmd_item;
		end
	end

	tal_exec u_exec (
		.item  (item_s1),
		.flags (flags_q),
		.res   (exec_res)
	);

	// Result register and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			flags_q     <= '0;
		end else begin
			if (advance) begin
				res_valid_q <= 1'b1;
				flags_q     <= exec_res.flags_out;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= exec_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

### hw/rtl/tal_shift.sv
`timescale 1ns / 1ps
// Barrel shifter with ARM shifter carry-out rules (LSL, LSR, ASR, ROR).
// Depends on tal_pkg.
module tal_shift (
	input  logic [tal_pkg::DATA_W-1:0] value,
	input  logic                       carry_in,
	input  tal_pkg::shift_ctl_t        ctl,
	output tal_pkg::shift_res_t        res
);

	logic                          amt_zero;
	logic                          amt_le_word;
	logic [5:0]                    amt_lo;
	logic [5:0]                    amt_clamp;
	logic [tal_pkg::DATA_W:0]      lsl_w;
	logic [tal_pkg::DATA_W:0]      lsr_w;
	logic signed [tal_pkg::DATA_W:0] asr_w;
	logic [2*tal_pkg::DATA_W-1:0]  ror_w;

	assign amt_zero    = (ctl.amount == '0);
	assign amt_le_word = (ctl.amount <= tal_pkg::SHAMT_WORD);
	assign amt_lo      = ctl.amount[5:0];
	assign amt_clamp   = amt_le_word ? amt_lo : tal_pkg::SHAMT_WORD[5:0];

	// Extended shifts: the extra bit catches the last bit shifted out
	assign lsl_w = {1'b0, value} << amt_lo;
	assign lsr_w = {value, 1'b0} >> amt_lo;
	assign asr_w = $signed({value, 1'b0}) >>> amt_clamp;
	assign ror_w = {value, value} >> ctl.amount[4:0];

	// Select by kind; a zero amount passes the value and the carry through
	always_comb begin
		res.value = value;
		res.carry = carry_in;
		if (!amt_zero) begin
			unique case (ctl.kind)
				tal_pkg::SH_LSL: begin
					if (amt_le_word) begin
						res.value = lsl_w[tal_pkg::DATA_W-1:0];
						res.carry = lsl_w[tal_pkg::DATA_W];
					end else begin
						res.value = '0;
						res.carry = 1'b0;
					end
				end
				tal_pkg::SH_LSR: begin
					if (amt_le_word) begin
						res.value = lsr_w[tal_pkg::DATA_W:1];
						res.carry = lsr_w[0];
					end else begin
						res.value = '0;
						res.carry = 1'b0;
					end
				end
				tal_pkg::SH_ASR: begin
					res.value = asr_w[tal_pkg::DATA_W:1];
					res.carry = asr_w[0];
				end
				default: begin
					// ROR: carry is the new top bit, also for multiples of 32
					res.value = ror_w[tal_pkg::DATA_W-1:0];
					res.carry = ror_w[tal_pkg::DATA_W-1];
				end
			endcase
		end
	end

endmodule

### hw/rtl/tal_exec.sv
`timescale 1ns / 1ps
// Execute logic for one item: decode, adder, logic ops, multiply, shifter, flags.
// Depends on tal_pkg and tal_shift.
module tal_exec (
	input  tal_pkg::in_item_t                 item,
	input  logic [tal_pkg::FLAGS_W-1:0]       flags,
	output tal_pkg::out_item_t                res
);

	localparam int W = tal_pkg::DATA_W;

	logic [W-1:0]        a;
	logic [W-1:0]        b;
	logic                c_in;
	logic                v_in;

	// Operand setup
	logic [W-1:0]        add_x;
	logic [W-1:0]        add_y;
	logic                add_cin;
	logic [W:0]          sum_w;
	logic [W-1:0]        sum;
	logic                add_c;
	logic                add_v;
	logic [W-1:0]        prod;
	logic [4:0]          imm_amt;
	tal_pkg::shift_ctl_t sh_ctl;
	tal_pkg::shift_res_t sh_res;

	// Result selection
	logic [W-1:0]        r;
	logic                wr;
	logic                c_out;
	logic                v_out;
	logic                defined;

	assign a       = item.operand_a;
	assign b       = item.operand_b;
	assign c_in    = flags[tal_pkg::FLAG_C];
	assign v_in    = flags[tal_pkg::FLAG_V];
	assign imm_amt = b[4:0];

	// Adder and shifter operands
	always_comb begin
		add_x   = a;
		add_y   = b;
		add_cin = 1'b0;
		sh_ctl  = '{kind: tal_pkg::SH_LSL, amount: b[tal_pkg::SHAMT_W-1:0]};
		unique case (item.command) inside
			tal_pkg::CMD_ADC: add_cin = c_in;
			tal_pkg::CMD_SBC: begin
				add_y   = ~b;
				add_cin = c_in;
			end
			tal_pkg::CMD_NEG: begin
				add_x   = '0;
				add_y   = ~b;
				add_cin = 1'b1;
			end
			tal_pkg::CMD_CMP, tal_pkg::CMD_SUB, tal_pkg::CMD_CMP_IMM: begin
				add_y   = ~b;
				add_cin = 1'b1;
			end
			tal_pkg::CMD_LSR: sh_ctl.kind = tal_pkg::SH_LSR;
			tal_pkg::CMD_ASR: sh_ctl.kind = tal_pkg::SH_ASR;
			tal_pkg::CMD_ROR: sh_ctl.kind = tal_pkg::SH_ROR;
			tal_pkg::CMD_LSL_IMM: sh_ctl.amount = tal_pkg::SHAMT_W'(imm_amt);
			tal_pkg::CMD_LSR_IMM: begin
				sh_ctl.kind   = tal_pkg::SH_LSR;
				sh_ctl.amount = (imm_amt == '0) ? tal_pkg::SHAMT_WORD
				                                : tal_pkg::SHAMT_W'(imm_amt);
			end
			tal_pkg::CMD_ASR_IMM: begin
				sh_ctl.kind   = tal_pkg::SH_ASR;
				sh_ctl.amount = (imm_amt == '0) ? tal_pkg::SHAMT_WORD
				                                : tal_pkg::SHAMT_W'(imm_amt);
			end
			default: ;
		endcase
	end

	// Shared adder; overflow uses the operand as actually added
	assign sum_w = {1'b0, add_x} + {1'b0, add_y} + (W+1)'(add_cin);
	assign sum   = sum_w[W-1:0];
	assign add_c = sum_w[W];
	assign add_v = ~(add_x[W-1] ^ add_y[W-1]) & (add_x[W-1] ^ sum[W-1]);

	// Low word of the product
	assign prod = a * b;

	tal_shift u_shift (
		.value    (a),
		.carry_in (c_in),
		.ctl      (sh_ctl),
		.res      (sh_res)
	);

	// Result, write enable and carry/overflow selection
	always_comb begin
		r       = '0;
		wr      = 1'b1;
		c_out   = c_in;
		v_out   = v_in;
		defined = 1'b1;
		unique case (item.command) inside
			tal_pkg::CMD_AND: r = a & b;
			tal_pkg::CMD_TST: begin
				r  = a & b;
				wr = 1'b0;
			end
			tal_pkg::CMD_EOR: r = a ^ b;
			tal_pkg::CMD_ORR: r = a | b;
			tal_pkg::CMD_BIC: r = a & ~b;
			tal_pkg::CMD_MVN: r = ~b;
			tal_pkg::CMD_MUL: r = prod;
			tal_pkg::CMD_MOV_IMM: r = b;
			tal_pkg::CMD_LSL, tal_pkg::CMD_LSR, tal_pkg::CMD_ASR, tal_pkg::CMD_ROR,
			tal_pkg::CMD_LSL_IMM, tal_pkg::CMD_LSR_IMM, tal_pkg::CMD_ASR_IMM: begin
				r     = sh_res.value;
				c_out = sh_res.carry;
			end
			tal_pkg::CMD_ADC, tal_pkg::CMD_SBC, tal_pkg::CMD_NEG,
			tal_pkg::CMD_ADD, tal_pkg::CMD_SUB: begin
				r     = sum;
				c_out = add_c;
				v_out = add_v;
			end
			tal_pkg::CMD_CMP, tal_pkg::CMD_CMN, tal_pkg::CMD_CMP_IMM: begin
				r     = sum;
				wr    = 1'b0;
				c_out = add_c;
				v_out = add_v;
			end
			default: begin
				// undefined code: no operation, flags unchanged
				wr      = 1'b0;
				defined = 1'b0;
			end
		endcase
	end

	assign res.result_value = r;
	assign res.write_result = wr;
	assign res.flags_out    = defined ? {r[W-1], (r == '0), c_out, v_out} : flags;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for thumb_alu_with_flags: directed and random Thumb ALU items.
// Depends on tal_pkg and the thumb_alu_with_flags RTL.
module tb_top;
	import tal_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 1650;
	localparam int QUIET_TAIL     = 200;
	localparam int MAX_REPORTS    = 10;

	typedef struct {
		in_item_t item;
		bit       drain;   // sender waits here until every result is back
	} stim_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	in_item_t  cmd_item = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	out_item_t res_item;

	stim_t             pending_items[$];
	out_item_t         expected_results[$];
	logic [FLAGS_W-1:0] model_flags = '0;
	int                total_items = 0;
	int                inputs_accepted = 0;
	int                fail_count = 0;
	int                idle_cycles = 0;
	int                send_gap = 0;
	int                rx_hold = 0;
	bit                long_hold_done = 1'b0;
	bit                in_fire = 1'b0;
	bit                timed_out = 1'b0;

	thumb_alu_with_flags u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	always #10 clk = ~clk;

	// 32-bit add with carry in; subtraction is x + ~y + cin
	function automatic logic [DATA_W-1:0] add_with_carry(input logic [DATA_W-1:0] x,
			input logic [DATA_W-1:0] y, input logic cin, output logic cout, output logic ovf);
		logic [DATA_W:0]   wide;
		logic [DATA_W-1:0] sum;
		wide = {1'b0, x} + {1'b0, y} + {{DATA_W{1'b0}}, cin};
		sum  = wide[DATA_W-1:0];
		cout = wide[DATA_W];
		ovf  = ~(x[31] ^ y[31]) & (x[31] ^ sum[31]);
		return sum;
	endfunction

	// Expected result of one command; flags_out is the new flag state
	function automatic out_item_t thumb_exec(input in_item_t it, input logic [FLAGS_W-1:0] fl);
		out_item_t         res;
		logic [DATA_W-1:0] a, b, r;
		logic              c, v, wr;
		logic [7:0]        amt;
		logic [4:0]        s;
		a   = it.operand_a;
		b   = it.operand_b;
		c   = fl[FLAG_C];
		v   = fl[FLAG_V];
		r   = '0;
		wr  = 1'b1;
		amt = b[7:0];
		s   = b[4:0];
		if (it.command > CMD_CMP_IMM) begin
			res.result_value = '0;
			res.write_result = 1'b0;
			res.flags_out    = fl;
			return res;
		end
		case (it.command)
			CMD_AND: r = a & b;
			CMD_EOR: r = a ^ b;
			CMD_LSL: begin
				if (amt == 0) r = a;
				else if (amt < 32) begin c = a[32 - amt]; r = a << amt; end
				else if (amt == 32) begin c = a[0]; r = '0; end
				else begin c = 1'b0; r = '0; end
			end
			CMD_LSR: begin
				if (amt == 0) r = a;
				else if (amt < 32) begin c = a[amt - 1]; r = a >> amt; end
				else if (amt == 32) begin c = a[31]; r = '0; end
				else begin c = 1'b0; r = '0; end
			end
			CMD_ASR: begin
				if (amt == 0) r = a;
				else if (amt < 32) begin c = a[amt - 1]; r = $signed(a) >>> amt; end
				else begin c = a[31]; r = {DATA_W{a[31]}}; end
			end
			CMD_ADC: r = add_with_carry(a, b, c, c, v);
			CMD_SBC: r = add_with_carry(a, ~b, c, c, v);
			CMD_ROR: begin
				if (amt == 0) r = a;
				else if (amt[4:0] == 0) begin c = a[31]; r = a; end
				else begin c = a[s - 1]; r = (a >> s) | (a << (32 - s)); end
			end
			CMD_TST: begin r = a & b; wr = 1'b0; end
			CMD_NEG: r = add_with_carry('0, ~b, 1'b1, c, v);
			CMD_CMP: begin r = add_with_carry(a, ~b, 1'b1, c, v); wr = 1'b0; end
			CMD_CMN: begin r = add_with_carry(a, b, 1'b0, c, v); wr = 1'b0; end
			CMD_ORR: r = a | b;
			CMD_MUL: r = a * b;
			CMD_BIC: r = a & ~b;
			CMD_MVN: r = ~b;
			CMD_LSL_IMM: begin
				if (s == 0) r = a;
				else begin c = a[32 - s]; r = a << s; end
			end
			// immediate amount of zero means 32 for LSR and ASR
			CMD_LSR_IMM: begin
				if (s == 0) begin c = a[31]; r = '0; end
				else begin c = a[s - 1]; r = a >> s; end
			end
			CMD_ASR_IMM: begin
				if (s == 0) begin c = a[31]; r = {DATA_W{a[31]}}; end
				else begin c = a[s - 1]; r = $signed(a) >>> s; end
			end
			CMD_ADD: r = add_with_carry(a, b, 1'b0, c, v);
			CMD_SUB: r = add_with_carry(a, ~b, 1'b1, c, v);
			CMD_MOV_IMM: r = b;
			default: begin r = add_with_carry(a, ~b, 1'b1, c, v); wr = 1'b0; end
		endcase
		res.result_value = r;
		res.write_result = wr;
		res.flags_out    = {r[31], r == '0, c, v};
		return res;
	endfunction

	task automatic queue_item(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b);
		stim_t st;
		st.item.command   = cmd;
		st.item.operand_a = a;
		st.item.operand_b = b;
		st.drain          = 1'b0;
		pending_items.push_back(st);
		total_items++;
	endtask

	// Operand biased toward the corner values
	function automatic logic [DATA_W-1:0] rand_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return 32'($urandom_range(0, 40));
			default: return $urandom;
		endcase
	endfunction

	// Shift amount word: random upper bits, low byte biased to the shift edges
	function automatic logic [DATA_W-1:0] rand_shift();
		logic [DATA_W-1:0] w;
		w = $urandom;
		case ($urandom_range(0, 3))
			0: w[7:0] = 8'($urandom_range(0, 33));
			1: w[7:0] = 8'(32 * $urandom_range(0, 7));
			2: w[7:0] = 8'($urandom_range(0, 255));
			default: ;
		endcase
		return w;
	endfunction

	function automatic bit is_shift(input logic [CMD_W-1:0] cmd);
		return cmd == CMD_LSL || cmd == CMD_LSR || cmd == CMD_ASR || cmd == CMD_ROR ||
			cmd == CMD_LSL_IMM || cmd == CMD_LSR_IMM || cmd == CMD_ASR_IMM;
	endfunction

	// Acceptance on both sides, result check and watchdog
	always @(posedge clk) begin
		out_item_t want;
		in_fire <= cmd_valid && !cmd_stall;
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("ERROR: unexpected result value=%h wr=%b flags=%h",
						res_item.result_value, res_item.write_result, res_item.flags_out);
			end else begin
				want = expected_results.pop_front();
				if (res_item.result_value !== want.result_value ||
						res_item.write_result !== want.write_result ||
						res_item.flags_out !== want.flags_out) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("ERROR: mismatch exp value=%h wr=%b flags=%h, got value=%h wr=%b flags=%h",
							want.result_value, want.write_result, want.flags_out,
							res_item.result_value, res_item.write_result, res_item.flags_out);
				end
			end
		end
		if (cmd_valid && !cmd_stall) begin
			want = thumb_exec(cmd_item, model_flags);
			model_flags = want.flags_out;
			expected_results.push_back(want);
			inputs_accepted++;
		end
	end

	// Sender: next item from the queue, random gaps, one drain pause
	always @(negedge clk) begin
		if (arst_n && (!cmd_valid || in_fire)) begin
			if (in_fire && inputs_accepted < total_items - QUIET_TAIL && $urandom_range(0, 9) == 0)
				send_gap = $urandom_range(1, 17);
			if (send_gap > 0) begin
				send_gap--;
				cmd_valid <= 1'b0;
			end else if (pending_items.size() > 0 && pending_items[0].drain) begin
				cmd_valid <= 1'b0;
				if (expected_results.size() == 0)
					void'(pending_items.pop_front());
			end else if (pending_items.size() > 0) begin
				cmd_item  <= pending_items[0].item;
				cmd_valid <= 1'b1;
				void'(pending_items.pop_front());
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stall bursts plus one long hold-off that fills the pipe
	always @(negedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold--;
			res_stall <= 1'b1;
		end else if (!long_hold_done && inputs_accepted >= 400) begin
			long_hold_done = 1'b1;
			rx_hold = 249;
			res_stall <= 1'b1;
		end else if (inputs_accepted < total_items - QUIET_TAIL && $urandom_range(0, 9) == 0) begin
			rx_hold = $urandom_range(0, 16);
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	initial begin
		logic [CMD_W-1:0] cmd;
		stim_t            pause;
		// directed: shift edges, carry chains, overflow, undefined codes
		queue_item(CMD_AND, '1, '0);
		queue_item(CMD_EOR, 32'h8000_0000, '0);
		queue_item(CMD_CMN, '1, 32'h1);
		queue_item(CMD_LSL, 32'h1234_5678, 32'hFFFF_FF00);
		queue_item(CMD_LSL, 32'h0000_0001, 32'd32);
		queue_item(CMD_LSL, '1, 32'd33);
		queue_item(CMD_LSR, 32'h8000_0000, 32'd32);
		queue_item(CMD_LSR, '1, 32'hFFFF_FF40);
		queue_item(CMD_ASR, 32'h8000_0001, 32'd40);
		queue_item(CMD_ROR, 32'h8000_0000, 32'd64);
		queue_item(CMD_ROR, 32'h0000_0003, 32'hFFFF_FF01);
		queue_item(CMD_ADD, 32'h7FFF_FFFF, 32'h1);
		queue_item(CMD_ADC, '0, '0);
		queue_item(CMD_SBC, '0, '0);
		queue_item(CMD_SBC, 32'd5, 32'd3);
		queue_item(CMD_NEG, '0, 32'h8000_0000);
		queue_item(CMD_TST, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
		queue_item(CMD_CMP, 32'd3, 32'd5);
		queue_item(CMD_MUL, '1, '1);
		queue_item(CMD_BIC, '1, 32'h8000_0000);
		queue_item(CMD_ORR, '0, '0);
		queue_item(CMD_MVN, '0, '0);
		queue_item(CMD_LSL_IMM, 32'h8000_0001, 32'hFFFF_FFE0);
		queue_item(CMD_LSR_IMM, 32'h8000_0000, 32'h0);
		queue_item(CMD_ASR_IMM, 32'h8000_0000, 32'hFFFF_FFFF);
		queue_item(CMD_SUB, '0, 32'h1);
		queue_item(CMD_MOV_IMM, '0, '0);
		queue_item(CMD_CMP_IMM, 32'd7, 32'd7);
		queue_item(5'd23, '1, '1);
		queue_item(5'd31, '1, '1);
		// random part, with one point where the sender waits for a full drain
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 800) begin
				pause.item  = '0;
				pause.drain = 1'b1;
				pending_items.push_back(pause);
			end
			if ($urandom_range(0, 19) == 0)
				cmd = 5'($urandom_range(23, 31));
			else
				cmd = 5'($urandom_range(0, 22));
			if (is_shift(cmd) && $urandom_range(0, 3) != 0)
				queue_item(cmd, rand_word(), rand_shift());
			else
				queue_item(cmd, rand_word(), rand_word());
		end

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		fork
			begin
				while (!(inputs_accepted == total_items && expected_results.size() == 0))
					@(negedge clk);
				repeat (10) @(negedge clk);
			end
			begin
				while (idle_cycles < WATCHDOG_LIMIT)
					@(negedge clk);
				timed_out = 1'b1;
				$display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
			end
		join_any

		if (!timed_out && fail_count == 0)
			$display("PASS thumb_alu_with_flags");
		else
			$display("FAIL thumb_alu_with_flags");
		$finish;
	end

endmodule
